### design/pps_pkg.sv
`default_nettype none
package pps_pkg;

	localparam int COORD_W = 34;
	localparam int DIST_W  = 69;
	localparam int PROD_W  = 240;
	localparam int MB_W    = 69;
	localparam int L2_W    = 40;
	localparam int W2SQ_W  = 34;
	localparam int TAN_W   = 30;
	localparam int K_W     = 5;
	localparam int HALF_W  = 17;

	localparam logic [K_W-1:0] STEER_MAX = 5'd30;
	localparam logic [59:0]    E18       = 60'hDE0B6B3A7640000;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] CFG_WHEELBASE = 2'd0;
	localparam logic [1:0] CFG_LOOKAHEAD = 2'd1;
	localparam logic [1:0] CFG_SPEED     = 2'd2;

	typedef logic [3:0] mop_t;
	localparam mop_t MOP_P    = 4'd0;
	localparam mop_t MOP_Q    = 4'd1;
	localparam mop_t MOP_HX   = 4'd2;
	localparam mop_t MOP_HY   = 4'd3;
	localparam mop_t MOP_RHS1 = 4'd4;
	localparam mop_t MOP_RHS  = 4'd5;
	localparam mop_t MOP_C2   = 4'd6;
	localparam mop_t MOP_LHS1 = 4'd7;
	localparam mop_t MOP_LHS  = 4'd8;
	localparam mop_t MOP_T1   = 4'd9;
	localparam mop_t MOP_T2   = 4'd10;

	typedef struct packed {
		logic accept;
		logic init;
		logic walk_init;
		logic walk_goal;
		logic issue;
		logic set_progress;
		logic mul_start;
		logic capture;
		logic srch_step;
		logic load_out;
		mop_t mop;
	} cmd_t;

	typedef struct packed {
		logic start_update;
		logic idx_end;
		logic pipe_empty;
		logic found;
		logic mul_busy;
		logic srch_done;
	} st_t;

	// tan(k deg) * 1e9, rounded
	function automatic logic [TAN_W-1:0] tan_e9(input logic [K_W-1:0] k);
		logic [TAN_W-1:0] t;
		case (k)
			5'd1:  t = 30'd17455065;
			5'd2:  t = 30'd34920769;
			5'd3:  t = 30'd52407779;
			5'd4:  t = 30'd69926812;
			5'd5:  t = 30'd87488664;
			5'd6:  t = 30'd105104235;
			5'd7:  t = 30'd122784561;
			5'd8:  t = 30'd140540835;
			5'd9:  t = 30'd158384440;
			5'd10: t = 30'd176326981;
			5'd11: t = 30'd194380309;
			5'd12: t = 30'd212556562;
			5'd13: t = 30'd230868191;
			5'd14: t = 30'd249328003;
			5'd15: t = 30'd267949192;
			5'd16: t = 30'd286745386;
			5'd17: t = 30'd305730681;
			5'd18: t = 30'd324919696;
			5'd19: t = 30'd344327613;
			5'd20: t = 30'd363970234;
			5'd21: t = 30'd383864035;
			5'd22: t = 30'd404026226;
			5'd23: t = 30'd424474816;
			5'd24: t = 30'd445228685;
			5'd25: t = 30'd466307658;
			5'd26: t = 30'd487732589;
			5'd27: t = 30'd509525449;
			5'd28: t = 30'd531709432;
			5'd29: t = 30'd554309051;
			5'd30: t = 30'd577350269;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

### design/pure_pursuit_steering.sv
// Pure pursuit steering on a route of waypoints, millimetre units.
// Input channel (in_valid / in_stall): one item per command. Clear and
// append are accepted in the idle state and give no result. A position update
// with both fixes good and a non-empty route gives one result item on the
// output channel (out_valid / out_stall); otherwise nothing comes out.
// An update walks the table twice through a five-stage distance pipeline,
// once for the nearest waypoint from the progress index on and once for the
// goal, then runs the steering maths on one shift-add multiplier (one
// multiplier bit a cycle) with a binary search over the angle table.
// in_stall is high for the whole of an update, so updates go one at a time;
// clear and append go at one item a cycle.
// A finished result sits in the output register; while out_stall holds it
// the next update may run but waits before loading its own result.
// Reset empties the route, zeroes the progress index and loads the register
// defaults (wheelbase 1000 mm, lookahead 4000 mm, speed 7680); table contents
// are not cleared. Configuration writes (cfg_we, cfg_index, cfg_data) go
// to registers and are meant for when the block is idle.
`default_nettype none
module pure_pursuit_steering import pps_pkg::*; #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [COORD_W-1:0] waypoint_east,
	input  logic [COORD_W-1:0] waypoint_north,
	input  logic [COORD_W-1:0] front_east,
	input  logic [COORD_W-1:0] front_north,
	input  logic [COORD_W-1:0] rear_east,
	input  logic [COORD_W-1:0] rear_north,
	input  logic               front_fix_ok,
	input  logic               rear_fix_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               route_done,
	output logic [15:0]        speed_cmd,
	output logic signed [5:0]  steer_deg
);

	cmd_t cmd;
	st_t  st;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	pps_dp #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.waypoint_east  (waypoint_east),
		.waypoint_north (waypoint_north),
		.front_east     (front_east),
		.front_north    (front_north),
		.rear_east      (rear_east),
		.rear_north     (rear_north),
		.front_fix_ok   (front_fix_ok),
		.rear_fix_ok    (rear_fix_ok),
		.route_done     (route_done),
		.speed_cmd      (speed_cmd),
		.steer_deg      (steer_deg)
	);

endmodule
`default_nettype wire

### design/pps_mul.sv
`default_nettype none
// shift-add multiplier, one multiplier bit a cycle; stops early once the
// remaining multiplier bits are all zero
module pps_mul import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              accum,
	input  logic [PROD_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output logic              busy,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] a_q;
	logic [MB_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (start) begin
			b_q <= b;
		end else begin
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			if (!accum) begin
				acc_q <= '0;
			end
		end else begin
			a_q <= a_q << 1;
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
		end
	end

	assign busy = (b_q != '0);
	assign prod = acc_q;

endmodule
`default_nettype wire

### design/pps_dp.sv
`default_nettype none
module pps_dp import pps_pkg::*; #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output st_t                st,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic [1:0]         opcode,
	input  logic [COORD_W-1:0] waypoint_east,
	input  logic [COORD_W-1:0] waypoint_north,
	input  logic [COORD_W-1:0] front_east,
	input  logic [COORD_W-1:0] front_north,
	input  logic [COORD_W-1:0] rear_east,
	input  logic [COORD_W-1:0] rear_north,
	input  logic               front_fix_ok,
	input  logic               rear_fix_ok,
	output logic               route_done,
	output logic [15:0]        speed_cmd,
	output logic signed [5:0]  steer_deg
);

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	// configuration
	logic [15:0]       wheelbase_q;
	logic [19:0]       lookahead_q;
	logic [15:0]       speed_q;
	logic [L2_W-1:0]   l2_q;
	logic [W2SQ_W-1:0] w2sq_q;
	logic [31:0]       wsq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 16'd1000;
			lookahead_q <= 20'd4000;
			speed_q     <= 16'd7680;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WHEELBASE: wheelbase_q <= cfg_data[15:0];
				CFG_LOOKAHEAD: lookahead_q <= cfg_data;
				CFG_SPEED:     speed_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign wsq = 32'(wheelbase_q) * 32'(wheelbase_q);

	always_ff @(posedge clk) begin
		l2_q   <= L2_W'(lookahead_q) * L2_W'(lookahead_q);
		w2sq_q <= {wsq, 2'b00};
	end

	// route table
	logic [COORD_W-1:0] mem_e [MAX_WAYPOINTS];
	logic [COORD_W-1:0] mem_n [MAX_WAYPOINTS];
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      progress_q;
	logic [AW-1:0]      bi_q;
	logic               room;

	assign room = (count_q < CW'(MAX_WAYPOINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			progress_q <= '0;
		end else if (cmd.accept) begin
			case (opcode)
				OP_CLEAR: begin
					count_q    <= '0;
					progress_q <= '0;
				end
				OP_APPEND: begin
					if (room) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.set_progress) begin
			progress_q <= bi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == OP_APPEND && room) begin
			mem_e[count_q[AW-1:0]] <= waypoint_east;
			mem_n[count_q[AW-1:0]] <= waypoint_north;
		end
	end

	assign st.start_update = (opcode == OP_UPDATE) && front_fix_ok && rear_fix_ok
		&& (count_q != '0);

	// position of this update
	logic [COORD_W-1:0] fe_q, fn_q, re_q, rn_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fe_q <= front_east;
			fn_q <= front_north;
			re_q <= rear_east;
			rn_q <= rear_north;
		end
	end

	// walk over the table
	logic [CW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.walk_init) begin
			idx_q <= CW'(progress_q);
		end else if (cmd.issue) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign st.idx_end = (idx_q >= count_q);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] ix_s1, ix_s2, ix_s3, ix_s4, ix_s5;
	logic [COORD_W-1:0] rde_s1, rdn_s1;
	logic [COORD_W-1:0] de_s2, dn_s2, de_s3, dn_s3, de_s4, dn_s4, de_s5, dn_s5;
	logic en_s2, nn_s2, en_s3, nn_s3, en_s4, nn_s4, en_s5, nn_s5;
	logic [2*HALF_W-1:0] ehh_s3, ehl_s3, ell_s3, nhh_s3, nhl_s3, nll_s3;
	logic [2*COORD_W-1:0] de2_s4, dn2_s4;
	logic [DIST_W-1:0] d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		rde_s1 <= mem_e[idx_q[AW-1:0]];
		rdn_s1 <= mem_n[idx_q[AW-1:0]];
		ix_s1  <= idx_q[AW-1:0];

		de_s2 <= (rde_s1 >= re_q) ? rde_s1 - re_q : re_q - rde_s1;
		dn_s2 <= (rdn_s1 >= rn_q) ? rdn_s1 - rn_q : rn_q - rdn_s1;
		en_s2 <= (rde_s1 < re_q);
		nn_s2 <= (rdn_s1 < rn_q);
		ix_s2 <= ix_s1;

		// squares from 17-bit halves
		ehh_s3 <= (2*HALF_W)'(de_s2[33:17]) * (2*HALF_W)'(de_s2[33:17]);
		ehl_s3 <= (2*HALF_W)'(de_s2[33:17]) * (2*HALF_W)'(de_s2[16:0]);
		ell_s3 <= (2*HALF_W)'(de_s2[16:0])  * (2*HALF_W)'(de_s2[16:0]);
		nhh_s3 <= (2*HALF_W)'(dn_s2[33:17]) * (2*HALF_W)'(dn_s2[33:17]);
		nhl_s3 <= (2*HALF_W)'(dn_s2[33:17]) * (2*HALF_W)'(dn_s2[16:0]);
		nll_s3 <= (2*HALF_W)'(dn_s2[16:0])  * (2*HALF_W)'(dn_s2[16:0]);
		de_s3  <= de_s2;
		dn_s3  <= dn_s2;
		en_s3  <= en_s2;
		nn_s3  <= nn_s2;
		ix_s3  <= ix_s2;

		de2_s4 <= ((2*COORD_W)'(ehh_s3) << 34) + ((2*COORD_W)'(ehl_s3) << 18)
			+ (2*COORD_W)'(ell_s3);
		dn2_s4 <= ((2*COORD_W)'(nhh_s3) << 34) + ((2*COORD_W)'(nhl_s3) << 18)
			+ (2*COORD_W)'(nll_s3);
		de_s4  <= de_s3;
		dn_s4  <= dn_s3;
		en_s4  <= en_s3;
		nn_s4  <= nn_s3;
		ix_s4  <= ix_s3;

		d_s5  <= DIST_W'(de2_s4) + DIST_W'(dn2_s4);
		de_s5 <= de_s4;
		dn_s5 <= dn_s4;
		en_s5 <= en_s4;
		nn_s5 <= nn_s4;
		ix_s5 <= ix_s4;
	end

	assign st.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);

	// nearest and goal selection
	logic               have_q, found_q;
	logic [DIST_W-1:0]  best_q, dist_q;
	logic [COORD_W-1:0] dx_q, dy_q;
	logic               dxn_q, dyn_q;
	logic               nearer, beyond;

	assign nearer = !have_q || (d_s5 < best_q);
	assign beyond = !found_q && (d_s5 >= DIST_W'(l2_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.walk_init) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (v_s5) begin
			if (!cmd.walk_goal) begin
				have_q <= 1'b1;
			end else if (beyond) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			bi_q <= progress_q;
		end else if (v_s5) begin
			if (!cmd.walk_goal) begin
				if (nearer) begin
					best_q <= d_s5;
					bi_q   <= ix_s5;
				end
			end else if (beyond) begin
				dist_q <= d_s5;
				dx_q   <= de_s5;
				dy_q   <= dn_s5;
				dxn_q  <= en_s5;
				dyn_q  <= nn_s5;
			end
		end
	end

	assign st.found = found_q;

	// heading, rear to front; a zero heading points east
	logic [COORD_W-1:0] hx_q, hy_q, hx_raw, hy_raw;
	logic               hxn_q, hyn_q;

	assign hx_raw = (fe_q >= re_q) ? fe_q - re_q : re_q - fe_q;
	assign hy_raw = (fn_q >= rn_q) ? fn_q - rn_q : rn_q - fn_q;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			if (hx_raw == '0 && hy_raw == '0) begin
				hx_q  <= COORD_W'(1);
				hxn_q <= 1'b0;
			end else begin
				hx_q  <= hx_raw;
				hxn_q <= (fe_q < re_q);
			end
			hy_q  <= hy_raw;
			hyn_q <= (fn_q < rn_q);
		end
	end

	// binary search for the largest angle that still holds
	logic [K_W-1:0] lo_q, hi_q, mid;
	logic [K_W:0]   mid_sum;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid     = mid_sum[K_W:1];

	logic [PROD_W-1:0] lhs_q, rhs_q, t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.init) begin
			lo_q <= '0;
			hi_q <= STEER_MAX;
		end else if (cmd.srch_step) begin
			if (lhs_q >= t_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - 1'b1;
			end
		end
	end

	assign st.srch_done = (lo_q == hi_q);

	// shared multiplier
	logic [PROD_W-1:0] mul_a, prod;
	logic [MB_W-1:0]   mul_b;
	logic              mul_busy;
	logic [DIST_W-1:0] h2_q, cmag_q;
	logic [2*COORD_W-1:0] p_q, q_in;
	logic              cneg_q, pn, qn;
	logic [TAN_W-1:0]  tan_mid;

	assign tan_mid = tan_e9(mid);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			MOP_P: begin
				mul_a = PROD_W'(hx_q);
				mul_b = MB_W'(dy_q);
			end
			MOP_Q: begin
				mul_a = PROD_W'(hy_q);
				mul_b = MB_W'(dx_q);
			end
			MOP_HX: begin
				mul_a = PROD_W'(hx_q);
				mul_b = MB_W'(hx_q);
			end
			MOP_HY: begin
				mul_a = PROD_W'(hy_q);
				mul_b = MB_W'(hy_q);
			end
			MOP_RHS1: begin
				mul_a = PROD_W'(h2_q);
				mul_b = MB_W'(l2_q);
			end
			MOP_RHS: begin
				mul_a = rhs_q;
				mul_b = MB_W'(dist_q);
			end
			MOP_C2: begin
				mul_a = PROD_W'(cmag_q);
				mul_b = MB_W'(cmag_q);
			end
			MOP_LHS1: begin
				mul_a = lhs_q;
				mul_b = MB_W'(w2sq_q);
			end
			MOP_LHS: begin
				mul_a = lhs_q;
				mul_b = MB_W'(E18);
			end
			MOP_T1: begin
				mul_a = rhs_q;
				mul_b = MB_W'(tan_mid);
			end
			MOP_T2: begin
				mul_a = t_q;
				mul_b = MB_W'(tan_mid);
			end
			default: ;
		endcase
	end

	pps_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.accum  (cmd.mop == MOP_HY),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (prod)
	);

	assign st.mul_busy = mul_busy;

	// cross product c = hx*dy - hy*dx as sign and magnitude
	assign q_in = prod[2*COORD_W-1:0];
	assign pn   = (hxn_q != dyn_q);
	assign qn   = (hyn_q == dxn_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			case (cmd.mop)
				MOP_P: p_q <= prod[2*COORD_W-1:0];
				MOP_Q: begin
					if (pn == qn) begin
						cmag_q <= DIST_W'(p_q) + DIST_W'(q_in);
						cneg_q <= pn;
					end else if (p_q >= q_in) begin
						cmag_q <= DIST_W'(p_q - q_in);
						cneg_q <= pn;
					end else begin
						cmag_q <= DIST_W'(q_in - p_q);
						cneg_q <= qn;
					end
				end
				MOP_HY:   h2_q  <= prod[DIST_W-1:0];
				MOP_RHS1: rhs_q <= prod;
				MOP_RHS:  rhs_q <= prod;
				MOP_C2:   lhs_q <= prod;
				MOP_LHS1: lhs_q <= prod;
				MOP_LHS:  lhs_q <= prod;
				MOP_T1:   t_q   <= prod;
				MOP_T2:   t_q   <= prod;
				default: ;
			endcase
		end
	end

	// result register
	logic [K_W-1:0] mag;
	logic [5:0]     mag6;
	logic           done_q;
	logic [15:0]    spd_q;
	logic [5:0]     steer_q;

	assign mag  = (cmag_q != '0 && wheelbase_q != '0) ? lo_q : '0;
	assign mag6 = {1'b0, mag};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			done_q <= !found_q;
			if (found_q) begin
				spd_q   <= speed_q;
				steer_q <= cneg_q ? -mag6 : mag6;
			end else begin
				spd_q   <= '0;
				steer_q <= '0;
			end
		end
	end

	assign route_done = done_q;
	assign speed_cmd  = spd_q;
	assign steer_deg  = $signed(steer_q);

endmodule
`default_nettype wire

### design/pps_ctrl.sv
`default_nettype none
module pps_ctrl import pps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  st_t  st,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_W1    = 4'd2;
	localparam logic [3:0] S_W1END = 4'd3;
	localparam logic [3:0] S_W2I   = 4'd4;
	localparam logic [3:0] S_W2    = 4'd5;
	localparam logic [3:0] S_MGO   = 4'd6;
	localparam logic [3:0] S_MWAIT = 4'd7;
	localparam logic [3:0] S_SRCH  = 4'd8;
	localparam logic [3:0] S_STEP  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q, state_n;
	mop_t       mop_q, mop_n;
	logic       ov_q;

	always_comb begin
		cmd     = '0;
		cmd.mop = mop_q;
		state_n = state_q;
		mop_n   = mop_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && st.start_update) begin
					state_n = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init      = 1'b1;
				cmd.walk_init = 1'b1;
				state_n       = S_W1;
			end
			S_W1: begin
				cmd.issue = !st.idx_end;
				if (st.idx_end && st.pipe_empty) begin
					state_n = S_W1END;
				end
			end
			S_W1END: begin
				cmd.set_progress = 1'b1;
				state_n          = S_W2I;
			end
			S_W2I: begin
				cmd.walk_init = 1'b1;
				cmd.walk_goal = 1'b1;
				state_n       = S_W2;
			end
			S_W2: begin
				cmd.walk_goal = 1'b1;
				cmd.issue     = !st.idx_end && !st.found;
				if (st.pipe_empty && (st.idx_end || st.found)) begin
					if (st.found) begin
						mop_n   = MOP_P;
						state_n = S_MGO;
					end else begin
						state_n = S_OUT;
					end
				end
			end
			S_MGO: begin
				cmd.mul_start = 1'b1;
				state_n       = S_MWAIT;
			end
			S_MWAIT: begin
				if (!st.mul_busy) begin
					cmd.capture = 1'b1;
					state_n     = S_MGO;
					case (mop_q)
						MOP_P:    mop_n = MOP_Q;
						MOP_Q:    mop_n = MOP_HX;
						MOP_HX:   mop_n = MOP_HY;
						MOP_HY:   mop_n = MOP_RHS1;
						MOP_RHS1: mop_n = MOP_RHS;
						MOP_RHS:  mop_n = MOP_C2;
						MOP_C2:   mop_n = MOP_LHS1;
						MOP_LHS1: mop_n = MOP_LHS;
						MOP_LHS:  state_n = S_SRCH;
						MOP_T1:   mop_n = MOP_T2;
						MOP_T2:   state_n = S_STEP;
						default:  state_n = S_OUT;
					endcase
				end
			end
			S_SRCH: begin
				if (st.srch_done) begin
					state_n = S_OUT;
				end else begin
					mop_n   = MOP_T1;
					state_n = S_MGO;
				end
			end
			S_STEP: begin
				cmd.srch_step = 1'b1;
				state_n       = S_SRCH;
			end
			S_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mop_q   <= MOP_P;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			mop_q   <= mop_n;
			if (cmd.load_out) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;

endmodule
`default_nettype wire

### design/pps_chk.sv
`default_nettype none
module pps_chk import pps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        opcode,
	input logic              out_valid,
	input logic              out_stall,
	input logic              route_done,
	input logic [15:0]       speed_cmd,
	input logic signed [5:0] steer_deg
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(route_done) && $stable(speed_cmd)
			&& $stable(steer_deg))
		else $error("stalled result item changed");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && route_done |-> speed_cmd == '0 && steer_deg == '0)
		else $error("finished route with nonzero command");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steer_deg <= 6'sd30 && steer_deg >= -6'sd30)
		else $error("steering beyond limit");

	a_table_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode != OP_UPDATE |=> !in_stall)
		else $error("table command held the input");

endmodule

bind pure_pursuit_steering pps_chk u_chk (.*);
`default_nettype wire

### tb/sv/pure_pursuit_steering_tb.sv
`default_nettype none
module pure_pursuit_steering_tb;
	import pps_pkg::*;

	// small table so that the full-table case stays short
	localparam int ROUTE_MAX = 16;
	localparam int WATCHDOG  = 20000;
	localparam int HOLD_LEN  = 1500;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		bit [1:0]  op;
		bit [33:0] we, wn, fe, fn, re, rn;
		bit        ffix, rfix;
	} item_t;

	typedef struct {
		bit               done;
		bit [15:0]        spd;
		bit signed [5:0]  steer;
	} steer_res_t;

	// how a directed row is checked
	typedef enum int { CHK_PREDICT, CHK_NONE, CHK_TYPED } chk_t;

	localparam longint TAN_E9 [0:30] = '{
		0, 17455065, 34920769, 52407779, 69926812, 87488664, 105104235,
		122784561, 140540835, 158384440, 176326981, 194380309, 212556562,
		230868191, 249328003, 267949192, 286745386, 305730681, 324919696,
		344327613, 363970234, 383864035, 404026226, 424474816, 445228685,
		466307658, 487732589, 509525449, 531709432, 554309051, 577350269
	};

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = CFG_WHEELBASE;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  opcode = OP_CLEAR;
	logic [33:0] waypoint_east = '0, waypoint_north = '0;
	logic [33:0] front_east = '0, front_north = '0, rear_east = '0, rear_north = '0;
	logic        front_fix_ok = 0, rear_fix_ok = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        route_done;
	logic [15:0] speed_cmd;
	logic signed [5:0] steer_deg;

	pure_pursuit_steering #(
		.MAX_WAYPOINTS (ROUTE_MAX)
	) DUT (.*);

	always #4 clk = ~clk;

	// predictor state
	bit [33:0] wp_e [ROUTE_MAX];
	bit [33:0] wp_n [ROUTE_MAX];
	int        wp_count, wp_progress;
	bit [15:0] wheelbase, speed;
	bit [19:0] lookahead;

	steer_res_t pending_q[$];
	int  errors = 0;
	bit  quiet = 0;
	bit  hold_req = 0;
	int  stall_cycles = 0;

	function automatic bit [255:0] wp_dist2(int i, bit [33:0] pe, bit [33:0] pn);
		bit [255:0] de, dn;
		de = (wp_e[i] > pe) ? wp_e[i] - pe : pe - wp_e[i];
		dn = (wp_n[i] > pn) ? wp_n[i] - pn : pn - wp_n[i];
		return de * de + dn * dn;
	endfunction

	function automatic bit steer_predict(input item_t it, output steer_res_t r);
		bit [255:0] best, l2, d, p, q, cmag, h2, rhs, lhs, t, w2;
		bit [33:0]  hxm, hym, dxm, dym;
		bit hxn, hyn, dxn, dyn, pn, qn, cneg, have, found;
		int bi, goal, mag;
		r = '{0, 0, 0};
		if (it.op == OP_CLEAR) begin
			wp_count = 0;
			wp_progress = 0;
			return 0;
		end
		if (it.op == OP_APPEND) begin
			if (wp_count < ROUTE_MAX) begin
				wp_e[wp_count] = it.we;
				wp_n[wp_count] = it.wn;
				wp_count++;
			end
			return 0;
		end
		if (it.op != OP_UPDATE || !it.ffix || !it.rfix || wp_count == 0)
			return 0;
		have = 0;
		bi = wp_progress;
		for (int i = wp_progress; i < wp_count; i++) begin
			d = wp_dist2(i, it.re, it.rn);
			if (!have || d < best) begin
				have = 1;
				best = d;
				bi = i;
			end
		end
		wp_progress = bi;
		l2 = 256'(lookahead) * 256'(lookahead);
		found = 0;
		goal = 0;
		for (int i = wp_progress; i < wp_count; i++) begin
			if (wp_dist2(i, it.re, it.rn) >= l2) begin
				found = 1;
				goal = i;
				break;
			end
		end
		if (!found) begin
			r.done = 1;
			return 1;
		end
		hxn = it.fe < it.re; hxm = hxn ? it.re - it.fe : it.fe - it.re;
		hyn = it.fn < it.rn; hym = hyn ? it.rn - it.fn : it.fn - it.rn;
		if (hxm == 0 && hym == 0) begin
			hxm = 1;
			hxn = 0;
		end
		dxn = wp_e[goal] < it.re; dxm = dxn ? it.re - wp_e[goal] : wp_e[goal] - it.re;
		dyn = wp_n[goal] < it.rn; dym = dyn ? it.rn - wp_n[goal] : wp_n[goal] - it.rn;
		// cross product h x d as sign and magnitude
		p = 256'(hxm) * 256'(dym);
		pn = hxn ^ dyn;
		q = 256'(hym) * 256'(dxm);
		qn = !(hyn ^ dxn);
		if (pn == qn) begin
			cmag = p + q; cneg = pn;
		end else if (p >= q) begin
			cmag = p - q; cneg = pn;
		end else begin
			cmag = q - p; cneg = qn;
		end
		mag = 0;
		if (cmag != 0 && wheelbase != 0) begin
			w2 = 256'(wheelbase) * 2;
			h2 = 256'(hxm) * 256'(hxm) + 256'(hym) * 256'(hym);
			rhs = l2 * h2 * wp_dist2(goal, it.re, it.rn);
			lhs = w2 * w2 * (cmag * cmag) * 256'(E18);
			for (int k = 30; k >= 1; k--) begin
				t = 256'(TAN_E9[k] * TAN_E9[k]) * rhs;
				if (lhs >= t) begin
					mag = k;
					break;
				end
			end
		end
		r.spd = speed;
		r.steer = cneg ? -6'(mag) : 6'(mag);
		return 1;
	endfunction

	function automatic item_t mk(bit [1:0] op, bit [33:0] we, bit [33:0] wn,
			bit [33:0] fe, bit [33:0] fn, bit [33:0] re, bit [33:0] rn,
			bit ff, bit rf);
		mk = '{op, we, wn, fe, fn, re, rn, ff, rf};
	endfunction

	function automatic bit [33:0] rand34();
		return {2'($urandom_range(0, 3)), $urandom()};
	endfunction

	task automatic send_item(item_t it, chk_t chk = CHK_PREDICT,
			steer_res_t typed = '{0, 0, 0});
		int gap;
		steer_res_t r;
		bit got;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1;
		opcode         <= it.op;
		waypoint_east  <= it.we;
		waypoint_north <= it.wn;
		front_east     <= it.fe;
		front_north    <= it.fn;
		rear_east      <= it.re;
		rear_north     <= it.rn;
		front_fix_ok   <= it.ffix;
		rear_fix_ok    <= it.rfix;
		do @(posedge clk); while (in_stall);
		got = steer_predict(it, r);
		if (chk == CHK_TYPED)
			pending_q = {pending_q, typed};
		else if (chk == CHK_PREDICT && got)
			pending_q = {pending_q, r};
	endtask

	// wait for the block to go quiet before touching registers
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		wait (pending_q.size() == 0);
		repeat (2 * wp_count + 900) @(posedge clk);
	endtask

	task automatic cfg_write(bit [1:0] idx, bit [19:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_WHEELBASE: wheelbase = val[15:0];
			CFG_LOOKAHEAD: lookahead = val;
			CFG_SPEED:     speed = val[15:0];
			default: ;
		endcase
	endtask

	task automatic cfg_set(bit [15:0] w, bit [19:0] l, bit [15:0] s);
		drain();
		cfg_write(CFG_WHEELBASE, w);
		cfg_write(CFG_LOOKAHEAD, l);
		cfg_write(CFG_SPEED, s);
		@(posedge clk);
	endtask

	// clear, lay a route of short hops, then drive along it
	task automatic route_run(int n_pts, int n_upd);
		longint px[16], py[16];
		longint ang_x, ang_y, rx, ry;
		int j;
		px[0] = $urandom_range(1 << 20, 1 << 30);
		py[0] = $urandom_range(1 << 20, 1 << 30);
		for (int i = 1; i < n_pts; i++) begin
			px[i] = px[i-1] + $urandom_range(0, 6000) - 2000;
			py[i] = py[i-1] + $urandom_range(0, 6000) - 2000;
		end
		send_item(mk(OP_CLEAR, rand34(), rand34(), rand34(), rand34(), rand34(),
			rand34(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
		for (int i = 0; i < n_pts; i++)
			send_item(mk(OP_APPEND, px[i], py[i], rand34(), rand34(), rand34(),
				rand34(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
		for (int u = 0; u < n_upd; u++) begin
			j = (u * n_pts) / n_upd;
			rx = px[j] + $urandom_range(0, 800) - 400;
			ry = py[j] + $urandom_range(0, 800) - 400;
			if (j + 1 < n_pts && $urandom_range(0, 3) != 0) begin
				ang_x = px[j+1] - px[j];
				ang_y = py[j+1] - py[j];
			end else begin
				ang_x = $urandom_range(0, 4000) - 2000;
				ang_y = $urandom_range(0, 4000) - 2000;
			end
			send_item(mk(OP_UPDATE, rand34(), rand34(),
				rx + ang_x + $urandom_range(0, 600) - 300,
				ry + ang_y + $urandom_range(0, 600) - 300, rx, ry,
				$urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0));
		end
	endtask

	localparam bit [33:0] CMAX = 34'h3FFFFFFFF;

	initial begin
		item_t      dir_tab [15];
		chk_t       dir_chk [15];
		steer_res_t dir_res [15];
		steer_res_t r0;
		int sent;

		wheelbase = 1000; lookahead = 4000; speed = 7680;
		wp_count = 0; wp_progress = 0;

		r0 = '{0, 0, 0};
		dir_tab[0]  = mk(OP_UPDATE, 0, 0, 1000, 0, 0, 0, 1, 1);
		dir_tab[1]  = mk(OP_CLEAR, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1);
		dir_tab[2]  = mk(OP_APPEND, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[3]  = mk(OP_APPEND, 10000, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[4]  = mk(OP_APPEND, 20000, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[5]  = mk(OP_APPEND, CMAX, CMAX, 0, 0, 0, 0, 0, 0);
		dir_tab[6]  = mk(OP_UPDATE, 0, 0, 1000, 0, 0, 0, 0, 1);
		dir_tab[7]  = mk(OP_UPDATE, 0, 0, 1000, 0, 0, 0, 1, 0);
		dir_tab[8]  = mk(OP_UPDATE, 0, 0, 1000, 0, 0, 0, 1, 1);
		dir_tab[9]  = mk(OP_UPDATE, 0, 0, 0, 0, 0, 0, 1, 1);
		dir_tab[10] = mk(OP_UPDATE, 0, 0, 0, 1000, 0, 0, 1, 1);
		dir_tab[11] = mk(OP_UNUSED, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1);
		dir_tab[12] = mk(OP_UPDATE, 0, 0, 0, 5000, 3000, 100, 1, 1);
		dir_tab[13] = mk(OP_UPDATE, 0, 0, CMAX, CMAX, CMAX, CMAX, 1, 1);
		dir_tab[14] = mk(OP_UPDATE, 0, 0, 0, 0, CMAX, CMAX, 1, 1);
		foreach (dir_chk[i]) begin
			dir_chk[i] = CHK_PREDICT;
			dir_res[i] = r0;
		end
		// empty route, bad fixes, unused opcode: nothing comes back
		dir_chk[0] = CHK_NONE; dir_chk[6] = CHK_NONE;
		dir_chk[7] = CHK_NONE; dir_chk[11] = CHK_NONE;
		// goal dead ahead, and front on top of rear: straight on
		dir_chk[8] = CHK_TYPED; dir_res[8] = '{0, 7680, 0};
		dir_chk[9] = CHK_TYPED; dir_res[9] = '{0, 7680, 0};
		// parked on the last waypoint: route finished
		dir_chk[13] = CHK_TYPED; dir_res[13] = '{1, 0, 0};
		dir_chk[14] = CHK_TYPED; dir_res[14] = '{1, 0, 0};

		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i], dir_chk[i], dir_res[i]);

		// zero wheelbase and zero lookahead, then the extremes
		cfg_set(0, 0, 65535);
		cfg_write(CFG_UNUSED, 20'hFFFFF);
		route_run(4, 3);
		cfg_set(65535, 0, 1);
		route_run(4, 3);
		cfg_set(65535, 1, 0);
		route_run(5, 3);
		cfg_set(1, 1000000, 65535);
		route_run(5, 3);
		cfg_set(1000, 4000, 7680);

		sent = 0;
		hold_req = 1;
		while (sent < 75) begin
			if (sent > 0 && sent % 45 < 12 && $urandom_range(0, 3) == 0)
				cfg_set(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 12000)),
					16'($urandom()));
			quiet = $urandom_range(0, 5) == 0;
			if ($urandom_range(0, 4) != 0) begin
				int np, nu;
				np = $urandom_range(2, 12);
				nu = $urandom_range(2, 6);
				route_run(np, nu);
				sent += np + nu + 1;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_item(mk(2'($urandom_range(0, 3)), rand34(), rand34(), rand34(),
						rand34(), rand34(), rand34(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
					sent++;
				end
			end
		end
		quiet = 0;

		// fill the table past its end; the extra append is dropped
		cfg_set(1000, 4000, 7680);
		quiet = 1;
		send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i <= ROUTE_MAX; i++)
			send_item(mk(OP_APPEND, 34'd1000000 + i * 700, 34'd5000000 + (i % 7) * 300,
				0, 0, 0, 0, 0, 0));
		quiet = 0;
		send_item(mk(OP_UPDATE, 0, 0, 34'd1001000, 34'd5000500, 34'd1000000,
			34'd5000000, 1, 1));
		send_item(mk(OP_UPDATE, 0, 0, 34'd1800000, 34'd5001000, 34'd1700000,
			34'd5000000, 1, 1));

		drain();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		int n;
		steer_res_t e;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				n = HOLD_LEN;
				hold_req = 0;
			end else
				n = quiet ? 0 : $urandom_range(0, 18);
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!out_valid);
			if (pending_q.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (route_done !== e.done) begin
					$error("route_done: expected %0d, got %0d", e.done, route_done);
					errors++;
				end
				if (speed_cmd !== e.spd) begin
					$error("speed_cmd: expected %0d, got %0d", e.spd, speed_cmd);
					errors++;
				end
				if (steer_deg !== e.steer) begin
					$error("steer_deg: expected %0d, got %0d", e.steer, steer_deg);
					errors++;
				end
			end
		end
	end

	// no handshake on either side for too long: hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
